>>> hdl/quadtree_node_placement_defines.svh
// assertion macros used by the quadtree node placement rtl
// no dependencies; included by files that carry concurrent checks
`ifndef QUADTREE_NODE_PLACEMENT_DEFINES_SVH
`define QUADTREE_NODE_PLACEMENT_DEFINES_SVH

// same-cycle implication
`define QTNP_ASSERT_NOW(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("qtnp check failed");

// next-cycle implication
`define QTNP_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("qtnp check failed");

`endif

>>> hdl/qtnp_pkg.sv
// shared types and constants for the quadtree node placement block
// no dependencies; used by the lane, merge and top modules
package qtnp_pkg;

  localparam int LEVELS_DEF = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic signed [31:0] RST_REGION_CENTER = 32'sd0;
  localparam logic [30:0]        RST_REGION_HALF   = 31'd65536;
  localparam logic [31:0]        RST_GRID_SCALE    = 32'd8355840;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REGION_CENTER_X = 3'd0,
    CFG_REGION_CENTER_Y = 3'd1,
    CFG_REGION_HALF_X   = 3'd2,
    CFG_REGION_HALF_Y   = 3'd3,
    CFG_GRID_SCALE_X    = 3'd4,
    CFG_GRID_SCALE_Y    = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic signed [31:0] obj_center_x;
    logic signed [31:0] obj_center_y;
    logic [30:0]        obj_half_x;
    logic [30:0]        obj_half_y;
  } in_t;

  typedef struct packed {
    logic [2:0]  tree_level;
    logic [6:0]  cell_col;
    logic [6:0]  cell_row;
    logic [14:0] node_slot;
    logic        outside_region;
  } out_t;

  // per-stage load enables of the placement pipeline
  typedef struct packed {
    logic en_ends;
    logic en_offs;
    logic en_prod;
    logic en_grid;
    logic en_out;
  } pipe_ctl_t;

endpackage

>>> hdl/qtnp_axis_lane.sv
// one axis lane: box ends, containment, grid scaling and per-axis level
// depends on qtnp_pkg for the pipeline control struct
module qtnp_axis_lane #(
  parameter int LEVELS = qtnp_pkg::LEVELS_DEF
) (
  input  logic                          clk,
  input  qtnp_pkg::pipe_ctl_t           ctl,
  input  logic signed [31:0]            obj_center,
  input  logic [30:0]                   obj_half,
  input  logic signed [31:0]            region_center,
  input  logic [30:0]                   region_half,
  input  logic [31:0]                   grid_scale,
  output logic                          contained,
  output logic [LEVELS-1:0]             grid_lo,
  output logic [$clog2(LEVELS)-1:0]     axis_level
);

  localparam int LW = $clog2(LEVELS);

  // stage 1: box and region ends
  logic signed [33:0] omin, omax, rmin, rmax;
  // stage 2: offsets from region low edge
  logic [31:0]        off_lo, off_hi;
  logic               inside_offs;
  // stage 3: products
  logic [63:0]        prod_lo, prod_hi;
  logic               inside_prod;

  logic signed [33:0] d_lo, d_hi, d_top;
  logic [63:0]        prod_lo_c, prod_hi_c;
  logic [31:0]        lo_raw;
  logic [32:0]        hi_raw;
  logic [LEVELS-1:0]  lo_c, hi_c, diff;
  logic [LW-1:0]      msb;

  always_ff @(posedge clk) begin
    if (ctl.en_ends) begin
      omin <= {{2{obj_center[31]}}, obj_center} - {3'b000, obj_half};
      omax <= {{2{obj_center[31]}}, obj_center} + {3'b000, obj_half};
      rmin <= {{2{region_center[31]}}, region_center} - {3'b000, region_half};
      rmax <= {{2{region_center[31]}}, region_center} + {3'b000, region_half};
    end
  end

  assign d_lo  = omin - rmin;
  assign d_hi  = omax - rmin;
  assign d_top = rmax - omax;

  always_ff @(posedge clk) begin
    if (ctl.en_offs) begin
      off_lo      <= d_lo[31:0];
      off_hi      <= d_hi[31:0];
      inside_offs <= !d_lo[33] && !d_top[33];
    end
  end

  assign prod_lo_c = off_lo * grid_scale;
  assign prod_hi_c = off_hi * grid_scale;

  always_ff @(posedge clk) begin
    if (ctl.en_prod) begin
      prod_lo     <= prod_lo_c;
      prod_hi     <= prod_hi_c;
      inside_prod <= inside_offs;
    end
  end

  // floor low end, ceil high end, clamp both to the grid
  always_comb begin
    lo_raw = prod_lo[63:32];
    hi_raw = {1'b0, prod_hi[63:32]} + {32'd0, |prod_hi[31:0]};
    lo_c   = (lo_raw[31:LEVELS] != '0) ? '1 : lo_raw[LEVELS-1:0];
    hi_c   = (hi_raw[32:LEVELS] != '0) ? '1 : hi_raw[LEVELS-1:0];
    diff   = lo_c ^ hi_c;
    msb    = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (diff[i]) msb = LW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en_grid) begin
      contained  <= inside_prod;
      grid_lo    <= lo_c;
      axis_level <= LW'(LEVELS - 1) - msb;
    end
  end

endmodule

>>> hdl/qtnp_merge.sv
// merge stage: combines both axis lanes into level, cell and flat node slot
// depends on qtnp_pkg for the result struct and pipeline control
module qtnp_merge #(
  parameter int LEVELS = qtnp_pkg::LEVELS_DEF
) (
  input  logic                      clk,
  input  qtnp_pkg::pipe_ctl_t       ctl,
  input  logic                      inside_x,
  input  logic                      inside_y,
  input  logic [LEVELS-1:0]         lo_x,
  input  logic [LEVELS-1:0]         lo_y,
  input  logic [$clog2(LEVELS)-1:0] level_x,
  input  logic [$clog2(LEVELS)-1:0] level_y,
  output qtnp_pkg::out_t            result
);

  localparam int LW  = $clog2(LEVELS);
  localparam int LVW = (LW > 3) ? LW : 3;
  localparam int CW  = (LEVELS > 7) ? LEVELS : 7;
  localparam int SW  = (2 * LEVELS > 15) ? 2 * LEVELS : 15;

  logic [LW-1:0]     level;
  logic [LW:0]       sh;
  logic [LEVELS-1:0] col_full, row_full;
  logic [SW-1:0]     base, slot;
  logic [LVW-1:0]    level_w;
  logic [CW-1:0]     col_w, row_w;
  qtnp_pkg::out_t    result_next;

  always_comb begin
    level    = (level_x < level_y) ? level_x : level_y;
    sh       = (LW+1)'(LEVELS) - {1'b0, level};
    col_full = lo_x >> sh;
    row_full = lo_y >> sh;
    // (4^level - 1) / 3 is ones at the even bit positions below 2*level
    base = '0;
    for (int k = 0; k < LEVELS; k++) begin
      base[2*k] = (k < int'(level));
    end
    slot    = base + (SW'(row_full) << level) + SW'(col_full);
    level_w = LVW'(level);
    col_w   = CW'(col_full);
    row_w   = CW'(row_full);

    if (inside_x && inside_y) begin
      result_next.tree_level     = level_w[2:0];
      result_next.cell_col       = col_w[6:0];
      result_next.cell_row       = row_w[6:0];
      result_next.node_slot      = slot[14:0];
      result_next.outside_region = 1'b0;
    end else begin
      result_next                = '0;
      result_next.outside_region = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en_out) begin
      result <= result_next;
    end
  end

endmodule

>>> hdl/quadtree_node_placement.sv
// channel  | dir | handshake        | payload
// in       | in  | in_valid/stall   | qtnp_pkg::in_t  object box
// out      | out | out_valid/stall  | qtnp_pkg::out_t node placement
// cfg      | in  | cfg_wr_en        | cfg_index, cfg_data
// one beat per cycle while the output is not stalled; the x and y lanes register
// ends, offsets, 32x32 multiply, grid and level, followed by the merge register.
// rst is synchronous; it clears the stage valids and loads the configuration defaults.
// an output stall only backs up the pipeline as far as it is full; empty stages
// keep taking beats. depends on qtnp_pkg, qtnp_axis_lane and qtnp_merge.
`include "quadtree_node_placement_defines.svh"

module quadtree_node_placement #(
  parameter int LEVELS = qtnp_pkg::LEVELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  qtnp_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output qtnp_pkg::out_t                    out_data,
  input  logic                              cfg_wr_en,
  input  logic [qtnp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [qtnp_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int LW = $clog2(LEVELS);

  logic signed [31:0] region_center_x, region_center_y;
  logic [30:0]        region_half_x, region_half_y;
  logic [31:0]        grid_scale_x, grid_scale_y;

  logic [3:0]          stage_valid;
  logic [4:0]          open;
  qtnp_pkg::pipe_ctl_t ctl;

  logic              inside_x, inside_y;
  logic [LEVELS-1:0] lo_x, lo_y;
  logic [LW-1:0]     level_x, level_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_center_x <= qtnp_pkg::RST_REGION_CENTER;
      region_center_y <= qtnp_pkg::RST_REGION_CENTER;
      region_half_x   <= qtnp_pkg::RST_REGION_HALF;
      region_half_y   <= qtnp_pkg::RST_REGION_HALF;
      grid_scale_x    <= qtnp_pkg::RST_GRID_SCALE;
      grid_scale_y    <= qtnp_pkg::RST_GRID_SCALE;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        qtnp_pkg::CFG_REGION_CENTER_X: region_center_x <= cfg_data;
        qtnp_pkg::CFG_REGION_CENTER_Y: region_center_y <= cfg_data;
        qtnp_pkg::CFG_REGION_HALF_X:   region_half_x   <= cfg_data[30:0];
        qtnp_pkg::CFG_REGION_HALF_Y:   region_half_y   <= cfg_data[30:0];
        qtnp_pkg::CFG_GRID_SCALE_X:    grid_scale_x    <= cfg_data;
        qtnp_pkg::CFG_GRID_SCALE_Y:    grid_scale_y    <= cfg_data;
        default: ;
      endcase
    end
  end

  // a stage loads when it is empty or its contents move on
  always_comb begin
    open[4] = !out_valid || !out_stall;
    for (int k = 3; k >= 0; k--) begin
      open[k] = !stage_valid[k] || open[k+1];
    end
    ctl.en_ends = open[0];
    ctl.en_offs = open[1];
    ctl.en_prod = open[2];
    ctl.en_grid = open[3];
    ctl.en_out  = open[4];
  end

  assign in_stall = !open[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (open[0]) stage_valid[0] <= in_valid;
      for (int k = 1; k < 4; k++) begin
        if (open[k]) stage_valid[k] <= stage_valid[k-1];
      end
      if (open[4]) out_valid <= stage_valid[3];
    end
  end

  qtnp_axis_lane #(.LEVELS(LEVELS)) u_lane_x (
    .clk           (clk),
    .ctl           (ctl),
    .obj_center    (in_data.obj_center_x),
    .obj_half      (in_data.obj_half_x),
    .region_center (region_center_x),
    .region_half   (region_half_x),
    .grid_scale    (grid_scale_x),
    .contained     (inside_x),
    .grid_lo       (lo_x),
    .axis_level    (level_x)
  );

  qtnp_axis_lane #(.LEVELS(LEVELS)) u_lane_y (
    .clk           (clk),
    .ctl           (ctl),
    .obj_center    (in_data.obj_center_y),
    .obj_half      (in_data.obj_half_y),
    .region_center (region_center_y),
    .region_half   (region_half_y),
    .grid_scale    (grid_scale_y),
    .contained     (inside_y),
    .grid_lo       (lo_y),
    .axis_level    (level_y)
  );

  qtnp_merge #(.LEVELS(LEVELS)) u_merge (
    .clk      (clk),
    .ctl      (ctl),
    .inside_x (inside_x),
    .inside_y (inside_y),
    .lo_x     (lo_x),
    .lo_y     (lo_y),
    .level_x  (level_x),
    .level_y  (level_y),
    .result   (out_data)
  );

  // input is only held off when the first stage is occupied
  `QTNP_ASSERT_NOW(a_stall_needs_full, clk, rst, in_stall, stage_valid[0])
  // an accepted beat lands in the first stage
  `QTNP_ASSERT_NEXT(a_accept_fills, clk, rst, in_valid && !in_stall, stage_valid[0])
  // a root placement for an outside box carries no cell or slot
  `QTNP_ASSERT_NOW(a_outside_zero, clk, rst, out_valid && out_data.outside_region,
    out_data.tree_level == 3'd0 && out_data.node_slot == 15'd0 &&
    out_data.cell_col == 7'd0 && out_data.cell_row == 7'd0)
  // a full pipeline under a stalled output must block the input
  `QTNP_ASSERT_NOW(a_full_chain_stalls, clk, rst,
    out_valid && out_stall && stage_valid == 4'hf, in_stall)

endmodule

>>> dv/quadtree_node_placement_tb.sv
// self-checking bench for quadtree_node_placement: streams object boxes under several
// region settings and checks every node placement against an in-bench placement model
// depends on qtnp_pkg and the quadtree_node_placement rtl
`timescale 1ns / 100ps

module quadtree_node_placement_tb;

  localparam int LEVELS = qtnp_pkg::LEVELS_DEF;
  localparam logic [63:0] GRID_TOP = (64'd1 << LEVELS) - 1;
  localparam longint S32_MIN = -(longint'(1) << 31);
  localparam longint S32_MAX = (longint'(1) << 31) - 1;
  localparam int QUIET_LIMIT = 2000;

  // where a generated box center lands relative to the region on one axis
  typedef enum int {SPOT_INSIDE, SPOT_LOW_EDGE, SPOT_HIGH_EDGE, SPOT_BELOW, SPOT_ABOVE} spot_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  qtnp_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  qtnp_pkg::out_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [qtnp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [qtnp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // register image used for prediction
  logic signed [31:0] reg_cx = qtnp_pkg::RST_REGION_CENTER;
  logic signed [31:0] reg_cy = qtnp_pkg::RST_REGION_CENTER;
  logic [30:0] reg_hx = qtnp_pkg::RST_REGION_HALF;
  logic [30:0] reg_hy = qtnp_pkg::RST_REGION_HALF;
  logic [31:0] reg_sx = qtnp_pkg::RST_GRID_SCALE;
  logic [31:0] reg_sy = qtnp_pkg::RST_GRID_SCALE;

  qtnp_pkg::in_t  box_queue[$];
  qtnp_pkg::out_t placements_due[$];

  int burst_left = 0;
  int gap_left = 0;
  int stall_run = 0;
  int quiet_cycles = 0;
  bit sender_gappy = 1'b0;
  bit receiver_stalls = 1'b0;
  int mismatch_count = 0;
  int boxes_sent = 0;
  int outside_seen = 0;
  int deepest_seen = 0;
  int settings_used = 1;

  quadtree_node_placement uut (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_wr_en, .cfg_index, .cfg_data
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // floor of the low end, ceiling of the high end, both clamped to the grid
  function automatic void grid_span(input logic [63:0] off_lo, off_hi,
                                    input logic [31:0] scale,
                                    output logic [63:0] lo, hi);
    logic [63:0] p, q, qi;
    p = off_lo * {32'd0, scale};
    q = off_hi * {32'd0, scale};
    qi = (q >> 32) + (q[31:0] != 0);
    lo = (p >> 32) > GRID_TOP ? GRID_TOP : (p >> 32);
    hi = qi > GRID_TOP ? GRID_TOP : qi;
  endfunction

  function automatic int axis_depth(logic [63:0] lo, logic [63:0] hi);
    logic [63:0] d;
    int top;
    d = lo ^ hi;
    top = 0;
    if (d == 0) return LEVELS - 1;
    for (int i = 0; i < 64; i++) if (d[i]) top = i;
    return LEVELS - 1 - (top > LEVELS - 1 ? LEVELS - 1 : top);
  endfunction

  function automatic qtnp_pkg::out_t place_box(qtnp_pkg::in_t box);
    longint omin_x, omax_x, omin_y, omax_y, rmin_x, rmax_x, rmin_y, rmax_y;
    logic [63:0] lo_x, hi_x, lo_y, hi_y, col, row, slot;
    int lvl, lvl_y;
    qtnp_pkg::out_t r;
    omin_x = longint'($signed(box.obj_center_x)) - longint'(box.obj_half_x);
    omax_x = longint'($signed(box.obj_center_x)) + longint'(box.obj_half_x);
    omin_y = longint'($signed(box.obj_center_y)) - longint'(box.obj_half_y);
    omax_y = longint'($signed(box.obj_center_y)) + longint'(box.obj_half_y);
    rmin_x = longint'(reg_cx) - longint'(reg_hx);
    rmax_x = longint'(reg_cx) + longint'(reg_hx);
    rmin_y = longint'(reg_cy) - longint'(reg_hy);
    rmax_y = longint'(reg_cy) + longint'(reg_hy);
    r = '0;
    // edges count as inside
    if (omin_x < rmin_x || omax_x > rmax_x || omin_y < rmin_y || omax_y > rmax_y) begin
      r.outside_region = 1'b1;
      return r;
    end
    grid_span(omin_x - rmin_x, omax_x - rmin_x, reg_sx, lo_x, hi_x);
    grid_span(omin_y - rmin_y, omax_y - rmin_y, reg_sy, lo_y, hi_y);
    lvl = axis_depth(lo_x, hi_x);
    lvl_y = axis_depth(lo_y, hi_y);
    if (lvl_y < lvl) lvl = lvl_y;
    col = lo_x >> (LEVELS - lvl);
    row = lo_y >> (LEVELS - lvl);
    slot = (((64'd1 << (2 * lvl)) - 1) / 3) + (row << lvl) + col;
    r.tree_level = 3'(lvl);
    r.cell_col = col[6:0];
    r.cell_row = row[6:0];
    r.node_slot = slot[14:0];
    return r;
  endfunction

  function automatic logic [31:0] scale_for(logic [30:0] half);
    logic [63:0] q;
    if (half == 0) return '1;
    q = (GRID_TOP << 31) / {33'd0, half};
    return q > 64'hFFFF_FFFF ? '1 : q[31:0];
  endfunction

  function automatic logic [31:0] pick_scale(logic [30:0] half);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return $urandom;
      default: return scale_for(half);
    endcase
  endfunction

  function automatic logic [30:0] pick_half(logic [30:0] region_half);
    logic [63:0] lim;
    lim = {33'd0, region_half} >> $urandom_range(0, 31);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return lim[30:0];
      default: return 31'({$urandom, $urandom} % (lim + 1));
    endcase
  endfunction

  function automatic logic [31:0] pick_center(logic signed [31:0] rc, logic [30:0] rh,
                                              logic [30:0] h, spot_t spot);
    longint lo, hi, v;
    logic [63:0] span;
    lo = longint'(rc) - longint'(rh) + longint'(h);
    hi = longint'(rc) + longint'(rh) - longint'(h);
    case (spot)
      SPOT_LOW_EDGE:  v = lo;
      SPOT_HIGH_EDGE: v = hi;
      SPOT_BELOW:     v = lo - 1;
      SPOT_ABOVE:     v = hi + 1;
      default: begin
        span = hi - lo;
        v = lo + longint'({$urandom, $urandom} % (span + 1));
      end
    endcase
    if (v < S32_MIN) v = S32_MIN;
    if (v > S32_MAX) v = S32_MAX;
    return v[31:0];
  endfunction

  function automatic spot_t pick_spot();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return SPOT_INSIDE;
    if (r < 86) return SPOT_LOW_EDGE;
    if (r < 92) return SPOT_HIGH_EDGE;
    if (r < 96) return SPOT_BELOW;
    return SPOT_ABOVE;
  endfunction

  // mostly boxes that fit the current region, some on or just past its edges, some noise
  function automatic qtnp_pkg::in_t make_box();
    qtnp_pkg::in_t b;
    if ($urandom_range(0, 9) == 0) begin
      b.obj_center_x = $urandom;
      b.obj_center_y = $urandom;
      b.obj_half_x = 31'($urandom);
      b.obj_half_y = 31'($urandom);
    end else begin
      b.obj_half_x = pick_half(reg_hx);
      b.obj_half_y = pick_half(reg_hy);
      b.obj_center_x = pick_center(reg_cx, reg_hx, b.obj_half_x, pick_spot());
      b.obj_center_y = pick_center(reg_cy, reg_hy, b.obj_half_y, pick_spot());
    end
    return b;
  endfunction

  function automatic void queue_box(logic [31:0] cx, logic [31:0] cy,
                                    logic [30:0] hx, logic [30:0] hy);
    qtnp_pkg::in_t b;
    b.obj_center_x = cx;
    b.obj_center_y = cy;
    b.obj_half_x = hx;
    b.obj_half_y = hy;
    box_queue.push_back(b);
  endfunction

  task automatic write_reg(qtnp_pkg::cfg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      qtnp_pkg::CFG_REGION_CENTER_X: reg_cx = value;
      qtnp_pkg::CFG_REGION_CENTER_Y: reg_cy = value;
      qtnp_pkg::CFG_REGION_HALF_X:   reg_hx = value[30:0];
      qtnp_pkg::CFG_REGION_HALF_Y:   reg_hy = value[30:0];
      qtnp_pkg::CFG_GRID_SCALE_X:    reg_sx = value;
      qtnp_pkg::CFG_GRID_SCALE_Y:    reg_sy = value;
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [31:0] cx, cy, input logic [30:0] hx, hy,
                              input logic [31:0] sx, sy);
    write_reg(qtnp_pkg::CFG_REGION_CENTER_X, cx);
    write_reg(qtnp_pkg::CFG_REGION_CENTER_Y, cy);
    write_reg(qtnp_pkg::CFG_REGION_HALF_X, {1'b0, hx});
    write_reg(qtnp_pkg::CFG_REGION_HALF_Y, {1'b0, hy});
    write_reg(qtnp_pkg::CFG_GRID_SCALE_X, sx);
    write_reg(qtnp_pkg::CFG_GRID_SCALE_Y, sy);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (box_queue.size() != 0 || in_valid || placements_due.size() != 0);
  endtask

  task automatic run_batch(int count);
    @(negedge clk);
    sender_gappy = $urandom_range(0, 3) != 0;
    receiver_stalls = $urandom_range(0, 3) != 0;
    repeat (count) box_queue.push_back(make_box());
    wait_drained();
  endtask

  // sender: bursts of beats with random gaps between them when sender_gappy is set
  always @(posedge clk) begin : driver
    if (rst) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        placements_due.push_back(place_box(in_data));
        boxes_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (box_queue.size() != 0) begin
          in_data <= box_queue.pop_front();
          in_valid <= 1'b1;
          if (sender_gappy) begin
            if (burst_left <= 1) begin
              burst_left <= $urandom_range(1, 24);
              gap_left <= $urandom_range(1, 6);
            end else begin
              burst_left <= burst_left - 1;
            end
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: alternating runs of stall and free cycles while receiver_stalls is set
  always @(posedge clk) begin : receiver
    if (rst) begin
      out_stall <= 1'b0;
      stall_run <= 0;
    end else if (stall_run > 0) begin
      stall_run <= stall_run - 1;
    end else if (!receiver_stalls) begin
      out_stall <= 1'b0;
    end else if (out_stall) begin
      out_stall <= 1'b0;
      stall_run <= $urandom_range(0, 15);
    end else begin
      out_stall <= 1'b1;
      stall_run <= $urandom_range(0, 7);
    end
  end

  always @(posedge clk) begin : monitor
    qtnp_pkg::out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (placements_due.size() == 0) begin
        report_mismatch("beat with no box pending", out_data, 0);
      end else begin
        want = placements_due.pop_front();
        if (out_data.tree_level !== want.tree_level)
          report_mismatch("tree_level", out_data.tree_level, want.tree_level);
        if (out_data.cell_col !== want.cell_col)
          report_mismatch("cell_col", out_data.cell_col, want.cell_col);
        if (out_data.cell_row !== want.cell_row)
          report_mismatch("cell_row", out_data.cell_row, want.cell_row);
        if (out_data.node_slot !== want.node_slot)
          report_mismatch("node_slot", out_data.node_slot, want.node_slot);
        if (out_data.outside_region !== want.outside_region)
          report_mismatch("outside_region", out_data.outside_region, want.outside_region);
        if (want.outside_region) outside_seen++;
        else if (want.tree_level == 3'(LEVELS - 1)) deepest_seen++;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", quiet_cycles);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [30:0] hx, hy;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset region spans -1.0 .. +1.0 on both axes
    @(negedge clk);
    queue_box(32'd0, 32'd0, 31'd65536, 31'd65536);
    queue_box(-32'sd65536, -32'sd65536, 31'd0, 31'd0);
    queue_box(32'd65536, 32'd65536, 31'd0, 31'd0);
    queue_box(32'd65536, -32'sd65536, 31'd0, 31'd0);
    queue_box(32'd65537, 32'd0, 31'd0, 31'd0);
    queue_box(32'd0, -32'sd65537, 31'd0, 31'd0);
    queue_box(32'd0, 32'd0, 31'd65537, 31'd0);
    queue_box(-32'sd32768, -32'sd32768, 31'd32768, 31'd32768);
    queue_box(32'd32768, 32'd32768, 31'd32767, 31'd32767);
    queue_box(32'd0, 32'd0, 31'd1, 31'd1);
    queue_box(32'h7FFF_FFFF, 32'h8000_0000, 31'd0, 31'd0);
    queue_box(32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    queue_box(32'd0, 32'd0, 31'd0, 31'd0);
    queue_box(32'd100, -32'sd100, 31'd5000, 31'd300);
    wait_drained();

    // extreme region, zero scale on x and full scale on y
    program_regs(32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, '0, '1);
    @(negedge clk);
    queue_box(32'h8000_0000, 32'h7FFF_FFFF, 31'd0, 31'd0);
    queue_box(32'hFFFF_FFFF, 32'd0, 31'd0, 31'd0);
    queue_box(32'hC000_0000, 32'h4000_0000, 31'h4000_0000, 31'h3FFF_FFFF);
    wait_drained();
    run_batch(60);

    // region collapsed to a point
    program_regs(32'd0, 32'd0, 31'd0, 31'd0, '1, '1);
    run_batch(60);
    program_regs($urandom, $urandom, 31'd65536, 31'd65536, '0, '0);
    run_batch(60);
    program_regs(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                 scale_for(31'h7FFF_FFFF), scale_for(31'h7FFF_FFFF));
    run_batch(60);
    program_regs(32'd0, 32'd0, 31'h100, 31'h7FFF_FFFF, '1, scale_for(31'h7FFF_FFFF));
    run_batch(60);

    for (int n = 0; n < 10; n++) begin
      hx = 31'($urandom >> $urandom_range(1, 24));
      hy = 31'($urandom >> $urandom_range(1, 24));
      program_regs($urandom, $urandom, hx, hy, pick_scale(hx), pick_scale(hy));
      run_batch(95);
    end

    wait_drained();
    repeat (12) @(posedge clk);
    $display("placed %0d boxes under %0d region settings", boxes_sent, settings_used);
    $display("%0d boxes fell outside the region, %0d landed at the deepest level",
             outside_seen, deepest_seen);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
